[hw/rtl/msmt_pkg.sv]
// shared types, constants and word functions of the multi-stream twister
package msmt_pkg;

  typedef logic [31:0] word_t;
  typedef logic [9:0]  idx_t;
  typedef logic [1:0]  op_t;

  localparam op_t OP_DRAW   = 2'd0;
  localparam op_t OP_SEED   = 2'd1;
  localparam op_t OP_UNSEED = 2'd2;

  localparam int unsigned DEFAULT_NUM_GENERATORS = 4;
  localparam int unsigned GEN_FIELD_W            = 7;

  localparam int unsigned WORDS     = 624;
  localparam int unsigned SHIFT_OFF = 397;

  localparam idx_t WORDS_POS = idx_t'(WORDS);
  localparam idx_t LAST_IDX  = idx_t'(WORDS - 1);
  localparam idx_t FAR_ADD   = idx_t'(SHIFT_OFF);
  localparam idx_t FAR_WRAP  = idx_t'(WORDS - SHIFT_OFF);

  localparam word_t TWIST_XOR    = 32'h9908_b0df;
  localparam word_t HIGH_BIT     = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7fff_ffff;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;
  localparam word_t SEED_MULT    = 32'd69069;
  localparam word_t DEFAULT_SEED = 32'd4357;

  // output tempering
  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // one twist step from the current, next and far words
  function automatic word_t twist(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_XOR;
    end
    return v;
  endfunction

  // index of the following word, wrapping at the end of the state
  function automatic idx_t nxt_idx(input idx_t k);
    return (k == LAST_IDX) ? '0 : idx_t'(k + idx_t'(1));
  endfunction

  // index of the word SHIFT_OFF places ahead, wrapping
  function automatic idx_t far_idx(input idx_t k);
    return (k >= FAR_WRAP) ? idx_t'(k - FAR_WRAP) : idx_t'(k + FAR_ADD);
  endfunction

endpackage

[hw/rtl/msmt_req_if.sv]
// request channel: operation, generator index and seed
interface msmt_req_if;
  logic                                  valid;
  logic                                  ready;
  msmt_pkg::op_t                         operation;
  logic [msmt_pkg::GEN_FIELD_W-1:0]      generator;
  msmt_pkg::word_t                       seed_value;

  modport source(output valid, operation, generator, seed_value, input ready);
  modport sink(input valid, operation, generator, seed_value, output ready);
endinterface

[hw/rtl/msmt_rsp_if.sv]
// response channel: random word and bad index flag
interface msmt_rsp_if;
  logic            valid;
  logic            ready;
  msmt_pkg::word_t random_word;
  logic            bad_index;

  modport source(output valid, random_word, bad_index, input ready);
  modport sink(input valid, random_word, bad_index, output ready);
endinterface

[hw/rtl/multi_stream_mersenne_twister_unit.sv]
// top level: several MT19937 generators sharing one word memory and one sequencer
//
// the unit keeps NUM_GENERATORS independent MT19937 generators in one memory of
// NUM_GENERATORS x 624 words, with a read position and a seeded flag per generator
// in flops. every request transfer gives exactly one response transfer. the unit
// works on one request at a time and takes the next one as soon as it is back in
// idle, even while the previous response still waits in the output register.
// a draw from an already twisted block passes through decode, memory read, temper
// and output load before the next request can be taken.
// a draw that finds the position at 624 first twists the whole 624-word state in
// place, one word per cycle through the two read ports and the write port; an
// unseeded generator is first filled with seed 4357. a seed request fills the
// 624 words, one multiply by 69069 per cycle. unseed and bad index requests go
// from decode straight to the output load. the word memory has no reset: a draw
// on an unseeded generator seeds it before it reads. there is no clearing pass
// after reset.
module multi_stream_mersenne_twister_unit #(
  parameter int unsigned NUM_GENERATORS = msmt_pkg::DEFAULT_NUM_GENERATORS
) (
  input  logic            clk,
  input  logic            rst,
  msmt_req_if.sink        req,
  msmt_rsp_if.source      rsp
);

  localparam int unsigned GW    = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
  localparam int unsigned DEPTH = NUM_GENERATORS * msmt_pkg::WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_FILL      = 4'd2;
  localparam logic [3:0] S_TW_PRE    = 4'd3;
  localparam logic [3:0] S_TW_LOAD   = 4'd4;
  localparam logic [3:0] S_TW_RUN    = 4'd5;
  localparam logic [3:0] S_DRAW_RD   = 4'd6;
  localparam logic [3:0] S_DRAW_WAIT = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0]             state;
  msmt_pkg::op_t          op_q;
  logic                   bad_q;
  logic [GW-1:0]          gen_q;
  logic [AW-1:0]          base;
  msmt_pkg::idx_t         idx;
  msmt_pkg::word_t        cur;        // seed recurrence value
  msmt_pkg::word_t        hold;       // word k of the twist, pre-update
  logic                   twist_after;
  msmt_pkg::word_t        res_word;
  logic                   res_bad;

  msmt_pkg::idx_t         pos    [NUM_GENERATORS];
  logic                   seeded [NUM_GENERATORS];

  logic                   out_valid;
  msmt_pkg::word_t        out_word;
  logic                   out_bad;
  logic                   out_load;

  // word memory, one write and two registered reads per cycle
  msmt_pkg::word_t        mem [DEPTH];
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  msmt_pkg::word_t        mem_wd;
  logic [AW-1:0]          rd_a_addr;
  logic [AW-1:0]          rd_b_addr;
  msmt_pkg::word_t        rd_a;
  msmt_pkg::word_t        rd_b;

  msmt_pkg::idx_t         k_next;
  logic                   req_bad;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;
  assign rsp.bad_index   = out_bad;

  // index check only matters for draw and seed
  assign req_bad = ((req.operation == msmt_pkg::OP_DRAW) ||
                    (req.operation == msmt_pkg::OP_SEED)) &&
                   ({1'b0, req.generator} >= (msmt_pkg::GEN_FIELD_W + 1)'(NUM_GENERATORS));

  assign k_next = msmt_pkg::nxt_idx(idx);

  // output register loads once the result is ready and the slot is free
  assign out_load = (state == S_FINISH) && (!out_valid || rsp.ready);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = base + AW'(idx);
    mem_wd    = cur;
    rd_a_addr = base + AW'(idx);
    rd_b_addr = base + AW'(msmt_pkg::far_idx(idx));
    unique case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_TW_PRE: begin
        rd_a_addr = base;
      end
      S_TW_LOAD: begin
        // reads for word 0 of the twist
        rd_a_addr = base + AW'(msmt_pkg::nxt_idx(idx));
        rd_b_addr = base + AW'(msmt_pkg::far_idx(idx));
      end
      S_TW_RUN: begin
        // write word k, fetch operands of word k+1
        mem_we    = 1'b1;
        mem_wd    = msmt_pkg::twist(hold, rd_a, rd_b);
        rd_a_addr = base + AW'(msmt_pkg::nxt_idx(k_next));
        rd_b_addr = base + AW'(msmt_pkg::far_idx(k_next));
      end
      S_DRAW_RD: begin
        rd_a_addr = base + AW'(pos[gen_q]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a <= mem[rd_a_addr];
    rd_b <= mem[rd_b_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int g = 0; g < NUM_GENERATORS; g++) begin
        pos[g]    <= msmt_pkg::WORDS_POS;
        seeded[g] <= 1'b0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q  <= req.operation;
            bad_q <= req_bad;
            gen_q <= req.generator[GW-1:0];
            base  <= AW'(int'(req.generator[GW-1:0]) * msmt_pkg::WORDS);
            cur   <= req.seed_value;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          idx     <= '0;
          res_bad <= bad_q;
          if (bad_q) begin
            res_word <= '1;
            state    <= S_FINISH;
          end else begin
            res_word <= '0;
            case (op_q)
              msmt_pkg::OP_SEED: begin
                twist_after <= 1'b0;
                state       <= S_FILL;
              end
              msmt_pkg::OP_DRAW: begin
                if (pos[gen_q] >= msmt_pkg::WORDS_POS) begin
                  if (!seeded[gen_q]) begin
                    cur         <= msmt_pkg::DEFAULT_SEED;
                    twist_after <= 1'b1;
                    state       <= S_FILL;
                  end else begin
                    state <= S_TW_PRE;
                  end
                end else begin
                  state <= S_DRAW_RD;
                end
              end
              msmt_pkg::OP_UNSEED: begin
                for (int g = 0; g < NUM_GENERATORS; g++) begin
                  pos[g]    <= msmt_pkg::WORDS_POS;
                  seeded[g] <= 1'b0;
                end
                state <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_FILL: begin
          cur <= msmt_pkg::word_t'(cur * msmt_pkg::SEED_MULT);
          if (idx == msmt_pkg::LAST_IDX) begin
            seeded[gen_q] <= 1'b1;
            pos[gen_q]    <= msmt_pkg::WORDS_POS;
            idx           <= '0;
            state         <= twist_after ? S_TW_PRE : S_FINISH;
          end else begin
            idx <= idx + msmt_pkg::idx_t'(1);
          end
        end
        S_TW_PRE: begin
          state <= S_TW_LOAD;
        end
        S_TW_LOAD: begin
          hold  <= rd_a;
          state <= S_TW_RUN;
        end
        S_TW_RUN: begin
          // old word k+1 becomes the current word of the next step
          hold <= rd_a;
          if (idx == msmt_pkg::LAST_IDX) begin
            pos[gen_q] <= '0;
            idx        <= '0;
            state      <= S_DRAW_RD;
          end else begin
            idx <= k_next;
          end
        end
        S_DRAW_RD: begin
          pos[gen_q] <= pos[gen_q] + msmt_pkg::idx_t'(1);
          state      <= S_DRAW_WAIT;
        end
        S_DRAW_WAIT: begin
          res_word <= msmt_pkg::temper(rd_a);
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_word <= res_word;
            out_bad  <= res_bad;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one request in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

  // a bad index response carries all ones
  a_bad_word: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_index) |-> (rsp.random_word == '1))
    else $error("bad index response without all-ones word");

  // a draw read never goes past the twisted block
  a_draw_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW_RD) |-> (pos[gen_q] < msmt_pkg::WORDS_POS))
    else $error("draw read beyond the last word");

endmodule
